// ===== rtl/lpcbm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcbm_pkg
// Shared types and constants of the lidar point / camera box matcher.
// ----------------------------------------------------------------------------
package lpcbm_pkg;

   localparam int NUM_COEFS = 36;
   localparam int PIX_W     = 11;
   localparam int ACC_W     = 59;   // four 32x24 products summed, plus negation headroom

   localparam logic [1:0] ACT_COEF  = 2'd0;
   localparam logic [1:0] ACT_BOX   = 2'd1;
   localparam logic [1:0] ACT_QUERY = 2'd2;
   localparam logic [1:0] ACT_CLEAR = 2'd3;

   localparam logic [2:0] VERD_BLUE   = 3'd0;
   localparam logic [2:0] VERD_YELLOW = 3'd1;
   localparam logic [2:0] VERD_BOTH   = 3'd2;
   localparam logic [2:0] VERD_NONE   = 3'd3;
   localparam logic [2:0] VERD_NOVIEW = 3'd4;
   localparam logic [2:0] VERD_NOBOX  = 3'd5;
   localparam logic [2:0] VERD_ACK    = 3'd6;

   localparam logic [1:0] CAM_CENTRE = 2'd0;
   localparam logic [1:0] CAM_RIGHT  = 2'd1;
   localparam logic [1:0] CAM_LEFT   = 2'd2;
   localparam logic [1:0] CAM_NONE   = 2'd3;

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_MARGIN = 2'd2;

   localparam logic [1:0] CLS_BLUE   = 2'd0;
   localparam logic [1:0] CLS_YELLOW = 2'd1;

   typedef struct packed {
      logic [1:0]         action;
      logic [5:0]         coef_index;
      logic signed [31:0] coef_value;
      logic [11:0]        box_xmin;
      logic [11:0]        box_xmax;
      logic [10:0]        box_ymin;
      logic [10:0]        box_ymax;
      logic [1:0]         box_class;
      logic               box_last;
      logic signed [23:0] point_x;
      logic signed [23:0] point_y;
      logic signed [23:0] point_z;
   } item_type;

   typedef struct packed {
      logic [11:0] xmin;
      logic [11:0] xmax;
      logic [10:0] ymin;
      logic [10:0] ymax;
      logic [1:0]  cls;
   } box_type;

   typedef struct packed {
      logic [10:0] width;
      logic [10:0] height;
      logic [7:0]  margin;
   } cfg_type;

   typedef struct packed {
      logic valid;
      logic pop;
   } queue_ctl_type;

endpackage

// ===== rtl/lidar_point_camera_box_matcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_point_camera_box_matcher
// Projects lidar points into three cameras and matches them to cone boxes.
// ----------------------------------------------------------------------------
// Load/clear items: taken from the queue and acknowledged from the result register.
// Query: for each camera tried, a 12-term MAC pipe on the coefficient RAM port
//   and the divider; then a scan over the loaded boxes, then the result.
//   One item in work at a time.
// A two-entry queue takes transfers while the back end is busy.
// Reset: synchronous; empties queue, unlocks and empties box table,
//   restores width 640, height 480, margin 0. Coefficients undefined.
// ----------------------------------------------------------------------------
module lidar_point_camera_box_matcher #(
   parameter int MAX_BOXES       = 32,
   parameter int POINT_FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_action,
   input  logic [5:0]         req_coef_index,
   input  logic signed [31:0] req_coef_value,
   input  logic [11:0]        req_box_xmin,
   input  logic [11:0]        req_box_xmax,
   input  logic [10:0]        req_box_ymin,
   input  logic [10:0]        req_box_ymax,
   input  logic [1:0]         req_box_class,
   input  logic               req_box_last,
   input  logic signed [23:0] req_point_x,
   input  logic signed [23:0] req_point_y,
   input  logic signed [23:0] req_point_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_verdict,
   output logic [1:0]         rsp_camera_used,
   output logic signed [12:0] rsp_proj_u,
   output logic signed [12:0] rsp_proj_v,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [10:0]        csr_write_data
);
   import lpcbm_pkg::*;

   cfg_type       cfg_ff;
   item_type      req_item, q_item;
   queue_ctl_type qctl;

   // configuration registers; an index past the list is ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width  <= 11'd640;
         cfg_ff.height <= 11'd480;
         cfg_ff.margin <= 8'd0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_WIDTH:  cfg_ff.width  <= csr_write_data;
            CSR_HEIGHT: cfg_ff.height <= csr_write_data;
            CSR_MARGIN: cfg_ff.margin <= csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   assign req_item = '{action: req_action, coef_index: req_coef_index,
                       coef_value: req_coef_value, box_xmin: req_box_xmin,
                       box_xmax: req_box_xmax, box_ymin: req_box_ymin,
                       box_ymax: req_box_ymax, box_class: req_box_class,
                       box_last: req_box_last, point_x: req_point_x,
                       point_y: req_point_y, point_z: req_point_z};

   lpcbm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .q_item    (q_item),
      .q_pop     (qctl.pop),
      .q_valid   (qctl.valid)
   );

   lpcbm_back #(
      .MAX_BOXES       (MAX_BOXES),
      .POINT_FRAC_BITS (POINT_FRAC_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_item          (q_item),
      .q_valid         (qctl.valid),
      .q_pop           (qctl.pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_verdict     (rsp_verdict),
      .rsp_camera_used (rsp_camera_used),
      .rsp_proj_u      (rsp_proj_u),
      .rsp_proj_v      (rsp_proj_v)
   );

endmodule

// ===== rtl/lpcbm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcbm_front
// Input side: takes request transfers into a two-entry queue.
// ----------------------------------------------------------------------------
module lpcbm_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  lpcbm_pkg::item_type req_item,
   output lpcbm_pkg::item_type q_item,
   input  logic                q_pop,
   output logic                q_valid
);
   import lpcbm_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ (q_pop && q_valid);
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop && q_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_item;
      end
   end

endmodule

// ===== rtl/lpcbm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcbm_div
// Restoring divider, one quotient bit a cycle, 11-bit quotient.
// Caller guarantees num < den * 2**11 and den > 0.
// ----------------------------------------------------------------------------
module lpcbm_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [lpcbm_pkg::ACC_W-1:0]          num,
   input  logic [lpcbm_pkg::ACC_W-1:0]          den,
   output logic [lpcbm_pkg::PIX_W-1:0]          quot,
   output logic                                 exact,
   output logic                                 busy
);
   import lpcbm_pkg::*;

   localparam int TW = ACC_W + PIX_W;

   logic [ACC_W-1:0] rem_ff;
   logic [ACC_W-1:0] den_ff;
   logic [PIX_W-1:0] q_ff;
   logic [3:0]       step_ff;
   logic             busy_ff;
   logic [TW-1:0]    trial;
   logic             fits;

   assign trial = {{PIX_W{1'b0}}, den_ff} << step_ff;
   assign fits  = {{PIX_W{1'b0}}, rem_ff} >= trial;
   assign quot  = q_ff;
   assign exact = (rem_ff == '0);
   assign busy  = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && step_ff == 4'd0) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= num;
         den_ff  <= den;
         q_ff    <= '0;
         step_ff <= 4'(PIX_W - 1);
      end else if (busy_ff) begin
         if (fits) begin
            rem_ff        <= rem_ff - trial[ACC_W-1:0];
            q_ff[step_ff] <= 1'b1;
         end
         if (step_ff != 4'd0) begin
            step_ff <= step_ff - 4'd1;
         end
      end
   end

endmodule

// ===== rtl/lpcbm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcbm_back
// Execution side: tables, projection, division, box scan, result register.
// ----------------------------------------------------------------------------
module lpcbm_back #(
   parameter int MAX_BOXES       = 32,
   parameter int POINT_FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lpcbm_pkg::cfg_type        cfg,
   input  lpcbm_pkg::item_type       q_item,
   input  logic                      q_valid,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [2:0]                rsp_verdict,
   output logic [1:0]                rsp_camera_used,
   output logic signed [12:0]        rsp_proj_u,
   output logic signed [12:0]        rsp_proj_v
);
   import lpcbm_pkg::*;

   localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int CW = $clog2(MAX_BOXES + 1);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_MAC   = 8'b0000_0010,
      S_NORM  = 8'b0000_0100,
      S_RANGE = 8'b0000_1000,
      S_DIV   = 8'b0001_0000,
      S_VIEW  = 8'b0010_0000,
      S_SCAN  = 8'b0100_0000,
      S_EMIT  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0]  cam_ff, cam_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] count_ff, count_in;
   logic        locked_ff, locked_in;
   logic        blue_ff, blue_in, yellow_ff, yellow_in;
   logic [12:0] pu_ff, pu_in;
   logic [2:0]  res_verd_ff, res_verd_in;
   logic [1:0]  res_cam_ff, res_cam_in;
   logic [10:0] res_u_ff, res_u_in, res_v_ff, res_v_in;

   logic        pt_ld, acc_clr, acc_neg, div_start, emit, coef_we, box_we;

   logic [31:0] coef_mem [NUM_COEFS];
   logic [31:0] coef_rd_ff;
   logic [5:0]  coef_addr;
   box_type     box_mem [MAX_BOXES];
   box_type     box_rd_ff;

   logic signed [23:0] px_ff, py_ff, pz_ff, opnd;
   logic               v1_ff, v2_ff, sv1_ff;
   logic [3:0]         t1_ff, t2_ff;
   logic signed [55:0] prod_ff;
   logic signed [ACC_W-1:0] acc_ff [3];

   logic [PIX_W-1:0] qu, qv;
   logic             eu, ev, ubusy, vbusy;
   logic             bad_range, in_view, hit, out_free;
   logic signed [ACC_W+PIX_W-1:0] lim;
   logic [13:0] pux, qvx, xlim, ylim;

   assign coef_addr = 6'(cam_ff) * 6'd12 + {2'b00, cnt_ff};
   assign out_free  = !rsp_valid || !rsp_stall;
   assign q_pop     = (state_ff == S_IDLE) && q_valid;

   // range of the quotient: both numerators non-negative and below 2**11 times the depth
   assign lim = {acc_ff[2], {PIX_W{1'b0}}};
   assign bad_range = acc_ff[0] < 0 || acc_ff[1] < 0 ||
                      (ACC_W+PIX_W)'(acc_ff[0]) >= lim ||
                      (ACC_W+PIX_W)'(acc_ff[1]) >= lim;

   assign in_view = (qu < cfg.width  || (qu == cfg.width  && eu)) &&
                    (qv < cfg.height || (qv == cfg.height && ev));

   assign pux  = {1'b0, pu_ff};
   assign qvx  = {3'b000, qv};
   assign xlim = {2'b00, box_rd_ff.xmax} + {6'd0, cfg.margin};
   assign ylim = {3'b000, box_rd_ff.ymax} + {6'd0, cfg.margin};
   assign hit  = (pux + {6'd0, cfg.margin} >= {2'b00, box_rd_ff.xmin}) &&
                 (pux < xlim || (pux == xlim && eu)) &&
                 (qvx + {6'd0, cfg.margin} >= {3'b000, box_rd_ff.ymin}) &&
                 (qvx < ylim || (qvx == ylim && ev));

   always_comb begin
      state_in    = state_ff;
      cam_in      = cam_ff;
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      count_in    = count_ff;
      locked_in   = locked_ff;
      blue_in     = blue_ff;
      yellow_in   = yellow_ff;
      pu_in       = pu_ff;
      res_verd_in = res_verd_ff;
      res_cam_in  = res_cam_ff;
      res_u_in    = res_u_ff;
      res_v_in    = res_v_ff;
      pt_ld       = 1'b0;
      acc_clr     = 1'b0;
      acc_neg     = 1'b0;
      div_start   = 1'b0;
      emit        = 1'b0;
      coef_we     = 1'b0;
      box_we      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               res_verd_in = VERD_ACK;
               res_cam_in  = CAM_NONE;
               res_u_in    = '0;
               res_v_in    = '0;
               state_in    = S_EMIT;
               case (q_item.action)
                  ACT_COEF: coef_we = (q_item.coef_index < 6'(NUM_COEFS));
                  ACT_BOX: begin
                     if (!locked_ff) begin
                        if (count_ff < CW'(MAX_BOXES)) begin
                           box_we   = 1'b1;
                           count_in = count_ff + CW'(1);
                        end
                        if (q_item.box_last) begin
                           locked_in = 1'b1;
                        end
                     end
                  end
                  ACT_CLEAR: begin
                     count_in  = '0;
                     locked_in = 1'b0;
                  end
                  default: begin
                     if (!locked_ff) begin
                        res_verd_in = VERD_NOBOX;
                     end else begin
                        pt_ld    = 1'b1;
                        acc_clr  = 1'b1;
                        cam_in   = CAM_CENTRE;
                        cnt_in   = '0;
                        state_in = S_MAC;
                     end
                  end
               endcase
            end
         end
         S_MAC: begin
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd13) begin
               state_in = S_NORM;
            end
         end
         S_NORM, S_RANGE, S_VIEW: begin
            if ((state_ff == S_NORM && acc_ff[2] == 0) ||
                (state_ff == S_RANGE && bad_range) ||
                (state_ff == S_VIEW && !in_view)) begin
               if (cam_ff == CAM_LEFT) begin
                  res_verd_in = VERD_NOVIEW;
                  res_cam_in  = CAM_NONE;
                  res_u_in    = '0;
                  res_v_in    = '0;
                  state_in    = S_EMIT;
               end else begin
                  cam_in   = cam_ff + 2'd1;
                  cnt_in   = '0;
                  acc_clr  = 1'b1;
                  state_in = S_MAC;
               end
            end else if (state_ff == S_NORM) begin
               acc_neg  = acc_ff[2] < 0;
               state_in = S_RANGE;
            end else if (state_ff == S_RANGE) begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end else begin
               case (cam_ff)
                  CAM_CENTRE: pu_in = {2'b00, qu} + {2'b00, cfg.width};
                  CAM_RIGHT:  pu_in = {2'b00, qu} + {1'b0, cfg.width, 1'b0};
                  default:    pu_in = {2'b00, qu};
               endcase
               idx_in    = '0;
               blue_in   = 1'b0;
               yellow_in = 1'b0;
               state_in  = S_SCAN;
            end
         end
         S_DIV: begin
            if (!ubusy && !vbusy) begin
               state_in = S_VIEW;
            end
         end
         S_SCAN: begin
            if (idx_ff < count_ff) begin
               idx_in = idx_ff + CW'(1);
            end
            if (sv1_ff && hit) begin
               if (cam_ff == CAM_RIGHT) begin
                  if (box_rd_ff.cls == CLS_YELLOW) yellow_in = 1'b1;
                  else blue_in = 1'b1;
               end else begin
                  if (box_rd_ff.cls == CLS_BLUE) blue_in = 1'b1;
                  else yellow_in = 1'b1;
               end
            end
            if (idx_ff >= count_ff && !sv1_ff) begin
               res_verd_in = (blue_ff && yellow_ff) ? VERD_BOTH :
                             blue_ff ? VERD_BLUE : yellow_ff ? VERD_YELLOW : VERD_NONE;
               res_cam_in  = cam_ff;
               res_u_in    = qu;
               res_v_in    = qv;
               state_in    = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         locked_ff <= 1'b0;
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         sv1_ff    <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         locked_ff <= locked_in;
         v1_ff     <= (state_ff == S_MAC) && (cnt_ff < 4'd12);
         v2_ff     <= v1_ff;
         sv1_ff    <= (state_ff == S_SCAN) && (idx_ff < count_ff);
         if (emit) rsp_valid <= 1'b1;
         else if (!rsp_stall) rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cam_ff      <= cam_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      blue_ff     <= blue_in;
      yellow_ff   <= yellow_in;
      pu_ff       <= pu_in;
      res_verd_ff <= res_verd_in;
      res_cam_ff  <= res_cam_in;
      res_u_ff    <= res_u_in;
      res_v_ff    <= res_v_in;
      if (emit) begin
         rsp_verdict     <= res_verd_ff;
         rsp_camera_used <= res_cam_ff;
         rsp_proj_u      <= {2'b00, res_u_ff};
         rsp_proj_v      <= {2'b00, res_v_ff};
      end
      if (pt_ld) begin
         px_ff <= q_item.point_x;
         py_ff <= q_item.point_y;
         pz_ff <= q_item.point_z;
      end
   end

   // tables: one write, one registered read each
   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[q_item.coef_index] <= q_item.coef_value;
      end
      coef_rd_ff <= coef_mem[coef_addr];
   end

   always_ff @(posedge clock) begin
      if (box_we) begin
         box_mem[count_ff[AW-1:0]] <= '{xmin: q_item.box_xmin, xmax: q_item.box_xmax,
                                        ymin: q_item.box_ymin, ymax: q_item.box_ymax,
                                        cls: q_item.box_class};
      end
      box_rd_ff <= box_mem[idx_ff[AW-1:0]];
   end

   // multiply-accumulate pipe: read, multiply, accumulate
   always_comb begin
      case (t1_ff[1:0])
         2'd0:    opnd = px_ff;
         2'd1:    opnd = py_ff;
         2'd2:    opnd = pz_ff;
         default: opnd = 24'sd1 <<< POINT_FRAC_BITS;
      endcase
   end

   always_ff @(posedge clock) begin
      t1_ff   <= cnt_ff;
      t2_ff   <= t1_ff;
      prod_ff <= $signed(coef_rd_ff) * opnd;
      if (acc_clr) begin
         for (int r = 0; r < 3; r++) acc_ff[r] <= '0;
      end else if (acc_neg) begin
         for (int r = 0; r < 3; r++) acc_ff[r] <= -acc_ff[r];
      end else if (v2_ff) begin
         acc_ff[t2_ff[3:2]] <= acc_ff[t2_ff[3:2]] + ACC_W'(prod_ff);
      end
   end

   lpcbm_div u_div_u (
      .clock (clock), .reset (reset), .start (div_start),
      .num (acc_ff[0]), .den (acc_ff[2]),
      .quot (qu), .exact (eu), .busy (ubusy)
   );

   lpcbm_div u_div_v (
      .clock (clock), .reset (reset), .start (div_start),
      .num (acc_ff[1]), .den (acc_ff[2]),
      .quot (qv), .exact (ev), .busy (vbusy)
   );

endmodule
